FILE: src/tlpte_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tlpte_pkg
// Shared types, sizes and codes of the three-level page table engine.
// ---------------------------------------------------------------------------
package tlpte_pkg;

   localparam int TABLE_PAGES = 64;
   localparam int LEVELS      = 3;

   localparam int IDX_W     = 9;
   localparam int ADDR_W    = 48;
   localparam int PFN_W     = ADDR_W - 12;
   localparam int VA_W      = 39;
   localparam int ENTRY_W   = 64;
   localparam int FLAGS_W   = 12;
   localparam int ASID_W    = 16;
   localparam int PAGE_W    = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
   localparam int NF_W      = $clog2(TABLE_PAGES + 1);
   localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int MEM_AW    = PAGE_W + IDX_W;
   localparam int MEM_DEPTH = TABLE_PAGES * (1 << IDX_W);

   localparam logic [FLAGS_W-1:0] FLAGS_RESET = FLAGS_W'(1027);

   localparam logic [1:0] FUNC_MAP   = 2'd0;
   localparam logic [1:0] FUNC_WALK  = 2'd1;
   localparam logic [1:0] FUNC_UNMAP = 2'd2;

   localparam logic [1:0] STAT_OK          = 2'd0;
   localparam logic [1:0] STAT_FULL        = 2'd1;
   localparam logic [1:0] STAT_NOT_MAPPED  = 2'd2;
   localparam logic [1:0] STAT_UNMAP_EMPTY = 2'd3;

   localparam logic CSR_TABLE_BASE  = 1'b0;
   localparam logic CSR_ENTRY_FLAGS = 1'b1;

   typedef enum logic [2:0] {
      SEQ_CLEAR,
      SEQ_IDLE,
      SEQ_READ,
      SEQ_EVAL,
      SEQ_PTR,
      SEQ_FINISH
   } seq_state_type;

   function automatic logic [IDX_W-1:0] level_index(logic [VA_W-1:0] va,
                                                    logic [LVL_W-1:0] lvl);
      logic [63:0] v;
      int          sh;
      v  = 64'(va);
      sh = 12 + IDX_W * (LEVELS - 1 - int'(lvl));
      level_index = IDX_W'(v >> sh);
   endfunction

endpackage
`default_nettype wire

FILE: src/three_level_page_table_engine.sv
`default_nettype none
// ---------------------------------------------------------------------------
// three_level_page_table_engine
// Keeps a three-level page table in an internal store and serves map,
// translate and unmap requests by walking it one level at a time.
//
// Request channel (req_*): one operation per transfer, taken only while the
// engine is idle; req_stall is high during an operation.
// Response channel (rsp_*): one result per request, held in an output
// register until transferred; a stalled response holds its value, and the
// engine accepts the next request while it waits.
// Configuration (csr_*): always ready; write only while no request is open.
// Sequencing: the table memory has one read port, which serves one read per
// level. An inner level passes through the read, evaluate and pointer-check
// states, the leaf through read and evaluate, between an accept and a finish
// state; a walk that ends early skips the rest, an undefined func goes to finish.
// Reset: the table store is cleared one entry per cycle, all 32768 entries, during
// which req_stall stays high. Configuration writes are taken meanwhile.
// ---------------------------------------------------------------------------
module three_level_page_table_engine (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_stall,
   input  wire [1:0]                  req_func,
   input  wire [tlpte_pkg::VA_W-1:0]   req_virt_addr,
   input  wire [tlpte_pkg::ADDR_W-1:0] req_phy_addr,
   input  wire [tlpte_pkg::ENTRY_W-1:0] req_attrs,
   input  wire [tlpte_pkg::ASID_W-1:0] req_asid,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output logic [1:0]                 rsp_status,
   output logic [tlpte_pkg::ADDR_W-1:0] rsp_phys_page,
   output logic                       rsp_freed_valid,
   output logic                       rsp_tlb_invalidate,
   output logic [tlpte_pkg::ASID_W-1:0] rsp_asid_out,
   input  wire                        csr_valid,
   output logic                       csr_ready,
   input  wire                        csr_index,
   input  wire [tlpte_pkg::ADDR_W-1:0] csr_wdata
);
   import tlpte_pkg::*;

   logic [ENTRY_W-1:0] mem [MEM_DEPTH];
   logic [ENTRY_W-1:0] rdata_ff;
   logic               mem_we;
   logic [MEM_AW-1:0]  mem_waddr;
   logic [MEM_AW-1:0]  mem_raddr;
   logic [ENTRY_W-1:0] mem_wdata;

   seq_state_type state_ff, state_in;
   logic [MEM_AW-1:0]  clr_ff, clr_in;
   logic [NF_W-1:0]    nf_ff, nf_in;
   logic [LVL_W-1:0]   level_ff, level_in;
   logic [PAGE_W-1:0]  page_ff, page_in;
   logic [ENTRY_W-1:0] ent_ff, ent_in;

   logic [PFN_W-1:0]   base_ff;
   logic [FLAGS_W-1:0] flags_ff;

   logic [1:0]         func_ff;
   logic [VA_W-1:0]    va_ff;
   logic [ADDR_W-1:0]  pa_ff;
   logic [ENTRY_W-1:0] attrs_ff;
   logic [ASID_W-1:0]  asid_ff;

   logic [1:0]         res_status_ff, res_status_in;
   logic [ADDR_W-1:0]  res_phys_ff, res_phys_in;
   logic               res_freed_ff, res_freed_in;
   logic               res_inval_ff, res_inval_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff;
   logic [ADDR_W-1:0]  rsp_phys_ff;
   logic               rsp_freed_ff;
   logic               rsp_inval_ff;
   logic [ASID_W-1:0]  rsp_asid_ff;

   logic               req_take;
   logic               rsp_load;
   logic               is_leaf;
   logic [IDX_W-1:0]   idx;
   logic [ENTRY_W-1:0] e;
   logic               e_zero;
   logic [PFN_W-1:0]   new_pfn;
   logic [ENTRY_W-1:0] new_entry;
   logic [ENTRY_W-1:0] leaf_entry;
   logic [PFN_W-1:0]   rel_pfn;
   logic               ptr_outside;

   assign req_stall = (state_ff != SEQ_IDLE);
   assign req_take  = req_valid && (state_ff == SEQ_IDLE);
   assign csr_ready = 1'b1;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_phys_page      = rsp_phys_ff;
   assign rsp_freed_valid    = rsp_freed_ff;
   assign rsp_tlb_invalidate = rsp_inval_ff;
   assign rsp_asid_out       = rsp_asid_ff;

   assign is_leaf    = (level_ff == LVL_W'(LEVELS - 1));
   assign idx        = level_index(va_ff, level_ff);
   assign e          = rdata_ff;
   assign e_zero     = (e == '0);
   assign new_pfn    = base_ff + PFN_W'(nf_ff);
   assign new_entry  = {{(ENTRY_W - ADDR_W){1'b0}}, new_pfn, 12'b0} | attrs_ff
                       | {{(ENTRY_W - FLAGS_W){1'b0}}, flags_ff};
   assign leaf_entry = {{(ENTRY_W - ADDR_W){1'b0}}, pa_ff} | attrs_ff
                       | {{(ENTRY_W - FLAGS_W){1'b0}}, flags_ff};
   assign rel_pfn    = ent_ff[ADDR_W-1:12] - base_ff;
   assign ptr_outside = (PFN_W'(rel_pfn) >= PFN_W'(TABLE_PAGES));
   assign mem_raddr  = {page_ff, idx};

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      nf_in         = nf_ff;
      level_in      = level_ff;
      page_in       = page_ff;
      ent_in        = ent_ff;
      res_status_in = res_status_ff;
      res_phys_in   = res_phys_ff;
      res_freed_in  = res_freed_ff;
      res_inval_in  = res_inval_ff;
      mem_we        = 1'b0;
      mem_waddr     = {page_ff, idx};
      mem_wdata     = '0;
      rsp_load      = 1'b0;
      unique case (state_ff)
         SEQ_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == MEM_AW'(MEM_DEPTH - 1)) begin
               state_in = SEQ_IDLE;
            end
         end
         SEQ_IDLE: begin
            if (req_take) begin
               level_in      = '0;
               page_in       = '0;
               res_status_in = STAT_OK;
               res_phys_in   = '0;
               res_freed_in  = 1'b0;
               res_inval_in  = 1'b0;
               if (req_func == FUNC_MAP || req_func == FUNC_WALK ||
                   req_func == FUNC_UNMAP) begin
                  state_in = SEQ_READ;
               end else begin
                  state_in = SEQ_FINISH;
               end
            end
         end
         SEQ_READ: begin
            state_in = SEQ_EVAL;
         end
         SEQ_EVAL: begin
            state_in = SEQ_FINISH;
            if (func_ff == FUNC_MAP) begin
               if (is_leaf) begin
                  if (e_zero) begin
                     mem_we    = 1'b1;
                     mem_wdata = leaf_entry;
                  end
               end else if (e_zero) begin
                  if (nf_ff >= NF_W'(TABLE_PAGES)) begin
                     res_status_in = STAT_FULL;
                  end else begin
                     mem_we    = 1'b1;
                     mem_wdata = new_entry;
                     ent_in    = new_entry;
                     nf_in     = nf_ff + 1'b1;
                     state_in  = SEQ_PTR;
                  end
               end else begin
                  ent_in   = e;
                  state_in = SEQ_PTR;
               end
            end else if (!is_leaf) begin
               if (e_zero) begin
                  res_status_in = STAT_NOT_MAPPED;
               end else begin
                  ent_in   = e;
                  state_in = SEQ_PTR;
               end
            end else if (func_ff == FUNC_WALK) begin
               if (e_zero) begin
                  res_status_in = STAT_NOT_MAPPED;
               end else begin
                  res_phys_in = {e[ADDR_W-1:12], 12'b0};
               end
            end else begin
               if (e_zero) begin
                  res_status_in = STAT_UNMAP_EMPTY;
               end else begin
                  res_phys_in  = {e[ADDR_W-1:12], 12'b0};
                  res_freed_in = 1'b1;
               end
               mem_we       = 1'b1;
               mem_wdata    = '0;
               res_inval_in = 1'b1;
            end
         end
         SEQ_PTR: begin
            if (ptr_outside) begin
               res_status_in = STAT_NOT_MAPPED;
               state_in      = SEQ_FINISH;
            end else begin
               page_in  = PAGE_W'(rel_pfn);
               level_in = level_ff + 1'b1;
               state_in = SEQ_READ;
            end
         end
         SEQ_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_CLEAR;
         clr_ff       <= '0;
         nf_ff        <= NF_W'(1);
         level_ff     <= '0;
         page_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         base_ff      <= '0;
         flags_ff     <= FLAGS_RESET;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         nf_ff        <= nf_in;
         level_ff     <= level_in;
         page_ff      <= page_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_TABLE_BASE) begin
               base_ff <= csr_wdata[ADDR_W-1:12];
            end else begin
               flags_ff <= csr_wdata[FLAGS_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      ent_ff        <= ent_in;
      res_status_ff <= res_status_in;
      res_phys_ff   <= res_phys_in;
      res_freed_ff  <= res_freed_in;
      res_inval_ff  <= res_inval_in;
      if (req_take) begin
         func_ff  <= req_func;
         va_ff    <= req_virt_addr;
         pa_ff    <= req_phy_addr;
         attrs_ff <= req_attrs;
         asid_ff  <= req_asid;
      end
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_phys_ff   <= res_phys_ff;
         rsp_freed_ff  <= res_freed_ff;
         rsp_inval_ff  <= res_inval_ff;
         rsp_asid_ff   <= res_inval_ff ? asid_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[mem_raddr];
   end

endmodule
`default_nettype wire
